// ===== sv/lat_pkg.sv =====
// Shared types and constants for the toroidal life automaton.
package lat_pkg;

   // Side of the stored grid; one memory word holds one full row.
   localparam int MAX_SIDE = 64;
   localparam int ADDR_W   = $clog2(MAX_SIDE);
   localparam int SIDE_W   = 7;
   localparam int COUNT_W  = 4;

   // Rule B3/S23 thresholds.
   localparam logic [COUNT_W-1:0] BIRTH_COUNT = 4'd3;
   localparam logic [COUNT_W-1:0] SURVIVE_CNT = 4'd2;

   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_STEP  = 2'd1,
      KIND_READ  = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [ADDR_W-1:0] row;
      logic [ADDR_W-1:0] col;
      logic              alive_in;
   } req_type;

   typedef struct packed {
      logic     alive_out;
      kind_type kind_done;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CELL_WR,
      ST_CELL_RD,
      ST_GEN_TOP,
      ST_GEN_FIRST,
      ST_GEN_RD,
      ST_GEN_CALC
   } state_type;

endpackage

// ===== sv/lat_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module lat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/life_automaton_torus_unit.sv =====
// Top level of the toroidal life automaton (rule B3/S23) with its row memory.
//
// Usage. An item is transferred on the request channel at a rising edge
// where start is high and busy is low. A write item (kind 0) sets one cell,
// a read item (kind 2) returns one cell, a step item (kind 1) advances the
// whole grid by one synchronous generation, and kind 3 does nothing.
// Every item gives exactly one result, shown on rsp_item for one cycle
// with rsp_valid high; the receiver cannot hold it off.
// Timing. Kind 3 strobes its result in the cycle after the transfer;
// reads and writes pass through ST_CELL_RD or ST_CELL_WR and the result
// register. A generation holds busy through ST_GEN_TOP, ST_GEN_FIRST and
// alternating ST_GEN_CALC and ST_GEN_RD over the rows, and strobes its
// result once busy is low again. Each row has a read and a compute-and-write
// step; the row window is primed with two reads. A new item may be
// transferred in the cycle that carries the previous result.
// Configuration. The side register is written over the csr channel, which
// is ready only while the block is idle and start is low. A side of 0 acts
// as 1, a side above 64 acts as 64.
// Reset. Synchronous reset clears the per-row valid bits, so every cell
// reads as dead at once; no clearing pass is needed. The side returns to 64.
module life_automaton_torus_unit
   import lat_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_item,
   output logic              rsp_valid,
   output rsp_type           rsp_item,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [SIDE_W-1:0] csr_data
);

   // Control and payload registers.
   state_type             state_ff, state_in;
   req_type               req_ff, req_in;
   logic                  inside_ff, inside_in;
   logic [ADDR_W-1:0]     row_ptr_ff, row_ptr_in;
   logic [MAX_SIDE-1:0]   top_ff, top_in;
   logic [MAX_SIDE-1:0]   mid_ff, mid_in;
   logic [MAX_SIDE-1:0]   row0_ff, row0_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;
   logic [SIDE_W-1:0]     side_ff;
   logic [MAX_SIDE-1:0]   row_valid_ff;
   logic                  rd_valid_ff;

   // Memory port signals.
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [MAX_SIDE-1:0]   wr_data;
   logic [ADDR_W-1:0]     rd_addr;
   logic [MAX_SIDE-1:0]   rd_data;

   // Derived values.
   logic [ADDR_W-1:0]     side_m1;
   logic [MAX_SIDE-1:0]   rd_row;
   logic [MAX_SIDE-1:0]   bot_row;
   logic [MAX_SIDE-1:0]   new_row;
   logic [MAX_SIDE-1:0]   mod_row;
   logic                  req_inside;

   // The grid lives in one memory, one row of cells per word. A generation
   // is done in place: the old copies of the row above, the row itself and
   // row 0 are held in registers, and the row below is still unwritten when
   // it is read, except for the wrap to row 0, which comes from row0_ff.
   lat_ram #(
      .WIDTH(MAX_SIDE),
      .DEPTH(MAX_SIDE)
   ) u_grid_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Effective side minus one: the highest row and column index in use.
   always_comb begin
      if (side_ff == '0) begin
         side_m1 = '0;
      end else if (side_ff > SIDE_W'(MAX_SIDE)) begin
         side_m1 = ADDR_W'(MAX_SIDE - 1);
      end else begin
         side_m1 = ADDR_W'(side_ff - SIDE_W'(1));
      end
   end

   assign req_inside = (req_item.row <= side_m1) && (req_item.col <= side_m1);

   // A row that was never written since reset reads as all dead.
   assign rd_row  = rd_valid_ff ? rd_data : '0;
   assign bot_row = (row_ptr_ff == side_m1) ? row0_ff : rd_row;

   // Cell write: merge the new value into the row just read.
   always_comb begin
      mod_row              = rd_row;
      mod_row[req_ff.col]  = req_ff.alive_in;
   end

   // One lane per column. Column wrap touches only the first lane and the
   // lane at the edge of the side in use; lanes beyond the side keep their
   // stored value.
   always_comb begin
      logic [ADDR_W-1:0]  lft_idx;
      logic [ADDR_W-1:0]  rgt_idx;
      logic [COUNT_W-1:0] cnt;
      for (int c = 0; c < MAX_SIDE; c++) begin
         lft_idx = (c == 0) ? side_m1 : ADDR_W'(c - 1);
         rgt_idx = (ADDR_W'(c) == side_m1) ? '0 : ADDR_W'(c + 1);
         cnt = COUNT_W'(top_ff[lft_idx]) + COUNT_W'(top_ff[c]) +
               COUNT_W'(top_ff[rgt_idx]) + COUNT_W'(mid_ff[lft_idx]) +
               COUNT_W'(mid_ff[rgt_idx]) + COUNT_W'(bot_row[lft_idx]) +
               COUNT_W'(bot_row[c]) + COUNT_W'(bot_row[rgt_idx]);
         if (ADDR_W'(c) > side_m1) begin
            new_row[c] = mid_ff[c];
         end else begin
            new_row[c] = (cnt == BIRTH_COUNT) || (mid_ff[c] && (cnt == SURVIVE_CNT));
         end
      end
   end

   // Sequencer: next state, memory access and result.
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      inside_in    = inside_ff;
      row_ptr_in   = row_ptr_ff;
      top_in       = top_ff;
      mid_in       = mid_ff;
      row0_in      = row0_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = row_ptr_ff;
      wr_data      = new_row;
      rd_addr      = ADDR_W'(row_ptr_ff + ADDR_W'(1));

      case (state_ff)
         ST_IDLE: begin
            rd_addr = req_item.row;
            if (start) begin
               req_in     = req_item;
               inside_in  = req_inside;
               row_ptr_in = '0;
               case (req_item.kind)
                  KIND_WRITE: state_in = ST_CELL_WR;
                  KIND_READ:  state_in = ST_CELL_RD;
                  KIND_STEP: begin
                     rd_addr  = side_m1;
                     state_in = ST_GEN_TOP;
                  end
                  default: begin
                     rsp_valid_in     = 1'b1;
                     rsp_in.alive_out = 1'b0;
                     rsp_in.kind_done = req_item.kind;
                  end
               endcase
            end
         end

         ST_CELL_WR: begin
            wr_en            = inside_ff;
            wr_addr          = req_ff.row;
            wr_data          = mod_row;
            rsp_valid_in     = 1'b1;
            rsp_in.alive_out = 1'b0;
            rsp_in.kind_done = req_ff.kind;
            state_in         = ST_IDLE;
         end

         ST_CELL_RD: begin
            rsp_valid_in     = 1'b1;
            rsp_in.alive_out = inside_ff && rd_row[req_ff.col];
            rsp_in.kind_done = req_ff.kind;
            state_in         = ST_IDLE;
         end

         ST_GEN_TOP: begin
            // Old last row arrives; fetch row 0.
            top_in   = rd_row;
            rd_addr  = '0;
            state_in = ST_GEN_FIRST;
         end

         ST_GEN_FIRST: begin
            // Row 0 arrives; keep a copy for the wrap at the bottom.
            mid_in   = rd_row;
            row0_in  = rd_row;
            state_in = ST_GEN_CALC;
         end

         ST_GEN_RD: begin
            state_in = ST_GEN_CALC;
         end

         ST_GEN_CALC: begin
            wr_en   = 1'b1;
            wr_addr = row_ptr_ff;
            wr_data = new_row;
            top_in  = mid_ff;
            mid_in  = bot_row;
            if (row_ptr_ff == side_m1) begin
               rsp_valid_in     = 1'b1;
               rsp_in.alive_out = 1'b0;
               rsp_in.kind_done = req_ff.kind;
               state_in         = ST_IDLE;
            end else begin
               row_ptr_in = ADDR_W'(row_ptr_ff + ADDR_W'(1));
               state_in   = ST_GEN_RD;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         side_ff      <= SIDE_W'(MAX_SIDE);
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_valid_ff  <= row_valid_ff[rd_addr];
         if (wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
         if (csr_valid && csr_ready) begin
            side_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      inside_ff  <= inside_in;
      row_ptr_ff <= row_ptr_in;
      top_ff     <= top_in;
      mid_ff     <= mid_in;
      row0_ff    <= row0_in;
      rsp_ff     <= rsp_in;
   end

   // A request offered in the same cycle takes precedence over a side write,
   // so the side never moves under an item that is being taken.
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE) && !start;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // The memory is only written while an item is at work.
   a_write_when_busy: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff != ST_IDLE))
      else $error("grid memory written while idle");

   // No write ever lands outside the square in use.
   a_write_in_side: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (wr_addr <= side_m1))
      else $error("grid row written beyond the side in use");

   // An item that does nothing answers in the very next cycle.
   a_none_answers: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.kind == KIND_NONE)) |=> rsp_valid)
      else $error("missing result for an unused kind");

   // The side cannot move under a running item.
   a_side_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |=> $stable(side_ff))
      else $error("side changed while an item was at work");

endmodule
